// File: hw/rtl/hdp_pkg.sv
// shared types, constants and lookup functions of the http date parser
// no dependencies; imported by hdp_front, hdp_back and http_date_parser
package hdp_pkg;

	localparam int JOB_QUEUE_DEPTH    = 4;
	localparam int RESULT_QUEUE_DEPTH = 2;

	// text layout: byte offsets of the captured fields
	localparam logic [4:0] TEXT_MIN_LEN = 5'd29;
	localparam logic [4:0] POS_DAY_0    = 5'd5;
	localparam logic [4:0] POS_DAY_1    = 5'd6;
	localparam logic [4:0] POS_MON_0    = 5'd8;
	localparam logic [4:0] POS_MON_1    = 5'd9;
	localparam logic [4:0] POS_MON_2    = 5'd10;
	localparam logic [4:0] POS_YEAR_0   = 5'd12;
	localparam logic [4:0] POS_YEAR_1   = 5'd13;
	localparam logic [4:0] POS_YEAR_2   = 5'd14;
	localparam logic [4:0] POS_YEAR_3   = 5'd15;
	localparam logic [4:0] POS_HOUR_0   = 5'd17;
	localparam logic [4:0] POS_HOUR_1   = 5'd18;
	localparam logic [4:0] POS_MIN_0    = 5'd20;
	localparam logic [4:0] POS_MIN_1    = 5'd21;
	localparam logic [4:0] POS_SEC_0    = 5'd23;
	localparam logic [4:0] POS_SEC_1    = 5'd24;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// month codes
	localparam int         MONTH_COUNT   = 12;
	localparam logic [3:0] MONTH_MAR     = 4'd2;
	localparam logic [3:0] MONTH_UNKNOWN = 4'd12;

	localparam logic [23:0] MONTH_NAMES [MONTH_COUNT] = '{
		24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
		24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
	};

	// day of a march-based year on which each month starts, jan first
	localparam logic [8:0] MONTH_START_DAY [MONTH_COUNT] = '{
		9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
		9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
	};

	// one word handed from the front to the back
	typedef struct packed {
		logic        err;
		logic        year_bad;
		logic [13:0] year;
		logic [3:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} job_t;

	typedef struct packed {
		logic               err;
		logic signed [38:0] secs;
	} result_t;

	function automatic logic [13:0] add_digit(input logic [13:0] acc, input logic [3:0] dv);
		return 14'(acc * 14'd10 + 14'(dv));
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		d = '0;
		if (m < MONTH_UNKNOWN) begin
			d = MONTH_START_DAY[m];
		end
		return d;
	endfunction

endpackage

// File: hw/rtl/hdp_fifo.sv
// small register queue with full and empty flags
// no package dependencies; used for the job and result queues
module hdp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/hdp_front.sv
// byte front end: tracks the text position and captures date fields
// depends on hdp_pkg; emits one job_t per text on its last byte
module hdp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    text_byte,
	input  logic          end_of_text,
	output logic          full,
	input  logic          job_full,
	output logic          job_push,
	output hdp_pkg::job_t job
);
	import hdp_pkg::*;

	logic [4:0]  pos_q, pos_d;
	logic [6:0]  day_q, day_d;
	logic [23:0] month_q, month_d;
	logic [13:0] year_q, year_d;
	logic        year_bad_q, year_bad_d;
	logic [6:0]  hour_q, hour_d;
	logic [6:0]  minute_q, minute_d;
	logic [6:0]  second_q, second_d;
	logic        field_bad_q, field_bad_d;
	logic        is_digit;
	logic [3:0]  dv;
	logic [3:0]  month_idx;
	logic        accept;

	assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
	assign dv       = is_digit ? 4'(text_byte - CHAR_ZERO) : 4'd0;

	always_comb begin
		pos_d       = pos_q;
		day_d       = day_q;
		month_d     = month_q;
		year_d      = year_q;
		year_bad_d  = year_bad_q;
		hour_d      = hour_q;
		minute_d    = minute_q;
		second_d    = second_q;
		field_bad_d = field_bad_q;
		if (pos_q < TEXT_MIN_LEN) begin
			pos_d = pos_q + 5'd1;
			unique case (pos_q) inside
				POS_DAY_0, POS_DAY_1: begin
					field_bad_d = field_bad_q | ~is_digit;
					day_d       = 7'(add_digit(14'(day_q), dv));
				end
				POS_MON_0, POS_MON_1, POS_MON_2: begin
					month_d = {month_q[15:0], text_byte};
				end
				POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
					year_bad_d = year_bad_q | ~is_digit;
					year_d     = add_digit(year_q, dv);
				end
				POS_HOUR_0, POS_HOUR_1: begin
					field_bad_d = field_bad_q | ~is_digit;
					hour_d      = 7'(add_digit(14'(hour_q), dv));
				end
				POS_MIN_0, POS_MIN_1: begin
					field_bad_d = field_bad_q | ~is_digit;
					minute_d    = 7'(add_digit(14'(minute_q), dv));
				end
				POS_SEC_0, POS_SEC_1: begin
					field_bad_d = field_bad_q | ~is_digit;
					second_d    = 7'(add_digit(14'(second_q), dv));
				end
				default: begin
				end
			endcase
		end
	end

	// names are distinct, so at most one compare hits
	always_comb begin
		month_idx = MONTH_UNKNOWN;
		for (int i = 0; i < MONTH_COUNT; i++) begin
			if (month_d == MONTH_NAMES[i]) begin
				month_idx = 4'(i);
			end
		end
	end

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign job_push = accept && end_of_text;

	always_comb begin
		job.err      = (pos_d < TEXT_MIN_LEN) || (month_idx == MONTH_UNKNOWN) || field_bad_d;
		job.year_bad = year_bad_d;
		job.year     = year_d;
		job.month    = month_idx;
		job.day      = day_d;
		job.hour     = hour_d;
		job.minute   = minute_d;
		job.second   = second_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			day_q       <= '0;
			month_q     <= '0;
			year_q      <= '0;
			year_bad_q  <= 1'b0;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			field_bad_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q       <= '0;
				day_q       <= '0;
				month_q     <= '0;
				year_q      <= '0;
				year_bad_q  <= 1'b0;
				hour_q      <= '0;
				minute_q    <= '0;
				second_q    <= '0;
				field_bad_q <= 1'b0;
			end else begin
				pos_q       <= pos_d;
				day_q       <= day_d;
				month_q     <= month_d;
				year_q      <= year_d;
				year_bad_q  <= year_bad_d;
				hour_q      <= hour_d;
				minute_q    <= minute_d;
				second_q    <= second_d;
				field_bad_q <= field_bad_d;
			end
		end
	end

endmodule

// File: hw/rtl/hdp_back.sv
// conversion back end: six-stage pipeline from civil date to epoch seconds
// depends on hdp_pkg; takes job_t words, gives result_t words
module hdp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  hdp_pkg::job_t    job,
	output logic             job_pop,
	output logic             res_valid,
	output hdp_pkg::result_t res,
	input  logic             res_ready
);
	import hdp_pkg::*;

	localparam logic [14:0] YEAR_BIAS   = 15'd400;
	localparam logic [28:0] ERA_RECIP   = 29'd10486;   // ceil(2^22 / 400)
	localparam logic [14:0] ERA_YEARS   = 15'd400;
	localparam logic [13:0] CENT_RECIP  = 14'd41;      // ceil(2^12 / 100)
	localparam logic signed [23:0] ERA_DAYS = 24'sd146097;
	// 1970-01-01 in the shifted day count, plus one for the 1-based day
	localparam logic signed [24:0] EPOCH_OFFSET_DAYS = 25'sd719469;
	localparam logic signed [17:0] DAY_SECONDS = 18'sd86400;

	logic adv;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic               err_s1, err_s2, err_s3, err_s4, err_s5, err_s6;
	logic [14:0]        yy_s1, yy_s2;
	logic [8:0]         doy_s1, doy_s2, doy_s3;
	logic [6:0]         day_s1, day_s2, day_s3, day_s4;
	logic [18:0]        tsum_s1, tsum_s2, tsum_s3, tsum_s4, tsum_s5;
	logic [5:0]         era_s2, era_s3;
	logic [8:0]         yoe_s3;
	logic signed [23:0] base_s4;
	logic [17:0]        doe_s4;
	logic signed [24:0] days_s5;
	logic signed [38:0] secs_s6;

	logic               lt_mar;
	logic [14:0]        yy_d;
	logic [18:0]        tsum_d;
	logic [28:0]        era_prod;
	logic [14:0]        yoe_full;
	logic signed [6:0]  era_m1;
	logic signed [23:0] base_d;
	logic [13:0]        cent_prod;
	logic [17:0]        doe_d;
	logic signed [24:0] days_d;
	logic signed [38:0] secs_d;

	// whole pipeline moves unless the last stage holds a word nobody takes
	assign adv       = !valid_s6 || res_ready;
	assign job_pop   = adv && job_valid;
	assign res_valid = valid_s6;
	assign res.err   = err_s6;
	assign res.secs  = secs_s6;

	// stage 1: march-based year with bias, month start, time of day
	assign lt_mar = job.month < MONTH_MAR;
	assign yy_d   = job.year_bad ? (YEAR_BIAS - 15'd1 - 15'(lt_mar))
	                             : (15'(job.year) + YEAR_BIAS - 15'(lt_mar));
	assign tsum_d = 19'(job.hour) * 19'd3600 + 19'(job.minute) * 19'd60
	              + 19'(job.second);

	// stage 2: era by reciprocal multiply
	assign era_prod = 29'(yy_s1) * ERA_RECIP;

	// stage 3: year of era
	assign yoe_full = yy_s2 - 15'(era_s2) * ERA_YEARS;

	// stage 4: era base days and day of era
	assign era_m1    = $signed({1'b0, era_s3}) - 7'sd1;
	assign base_d    = era_m1 * ERA_DAYS;
	assign cent_prod = 14'(yoe_s3) * CENT_RECIP;
	assign doe_d     = 18'(yoe_s3) * 18'd365 + 18'(yoe_s3[8:2]) - 18'(cent_prod[13:12])
	                 + 18'(doy_s3);

	// stage 5: days since epoch
	assign days_d = 25'(base_s4) + $signed({7'b0, doe_s4}) + $signed({18'b0, day_s4})
	              - EPOCH_OFFSET_DAYS;

	// stage 6: seconds
	assign secs_d = days_s5 * DAY_SECONDS + $signed({20'b0, tsum_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= job_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1  <= job.err;
			yy_s1   <= yy_d;
			doy_s1  <= month_start(job.month);
			day_s1  <= job.day;
			tsum_s1 <= tsum_d;

			err_s2  <= err_s1;
			yy_s2   <= yy_s1;
			era_s2  <= era_prod[27:22];
			doy_s2  <= doy_s1;
			day_s2  <= day_s1;
			tsum_s2 <= tsum_s1;

			err_s3  <= err_s2;
			era_s3  <= era_s2;
			yoe_s3  <= yoe_full[8:0];
			doy_s3  <= doy_s2;
			day_s3  <= day_s2;
			tsum_s3 <= tsum_s2;

			err_s4  <= err_s3;
			base_s4 <= base_d;
			doe_s4  <= doe_d;
			day_s4  <= day_s3;
			tsum_s4 <= tsum_s3;

			err_s5  <= err_s4;
			days_s5 <= days_d;
			tsum_s5 <= tsum_s4;

			err_s6  <= err_s5;
			secs_s6 <= err_s5 ? '0 : secs_d;
		end
	end

endmodule

// File: hw/rtl/http_date_parser.sv
// top level of the http date parser: front, job queue, back, result queue
// depends on hdp_pkg, hdp_fifo, hdp_front and hdp_back
//
// usage
//  - input side is a queue: drive text_byte and end_of_text, raise push; a word
//    is taken on each clock edge with push high and full low
//  - a date text is fed one byte per word, end_of_text high on its last byte;
//    every such word makes exactly one result, other bytes make none
//  - result side is a queue: while empty is low, parse_error and epoch_seconds
//    show the oldest result; it is taken on an edge with pop high
//  - unstalled throughput: one byte per cycle, and one text per cycle even for
//    one-byte texts; the six-stage back end pipeline takes a word every cycle
//  - a result passes the job queue, the six pipeline stages and the result
//    queue, all registered, before it becomes visible
//  - stall: when pop stays low the result queue fills, the pipeline freezes,
//    then the job queue fills and full rises; bytes still in flight keep
//    their captured fields, nothing is dropped
//  - reset (arst_n low) empties both queues, clears all pipeline valid bits
//    and returns the byte position and field captures to zero
//  - on parse_error, epoch_seconds reads zero
module http_date_parser #(
	parameter int JOB_DEPTH = hdp_pkg::JOB_QUEUE_DEPTH,
	parameter int RES_DEPTH = hdp_pkg::RESULT_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	output logic               empty,
	input  logic               pop,
	output logic               parse_error,
	output logic signed [38:0] epoch_seconds
);
	import hdp_pkg::*;

	// front to job queue
	job_t    job_in;
	logic    job_push;
	logic    job_full;
	// job queue to back
	job_t    job_out;
	logic    job_empty;
	logic    job_pop;
	// back to result queue
	result_t res;
	logic    res_valid;
	logic    res_full;
	logic    res_ready;
	result_t res_out;

	// front end: per-byte field capture, one job word per text
	hdp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.full        (full),
		.job_full    (job_full),
		.job_push    (job_push),
		.job         (job_in)
	);

	// decouples byte intake from the conversion pipeline
	hdp_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.pop     (job_pop),
		.rd_data (job_out),
		.full    (job_full),
		.empty   (job_empty)
	);

	// back end: civil date to seconds since epoch
	hdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !res_full;

	// output register stage seen by the receiver
	hdp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_valid && res_ready),
		.wr_data (res),
		.pop     (pop),
		.rd_data (res_out),
		.full    (res_full),
		.empty   (empty)
	);

	assign parse_error   = res_out.err;
	assign epoch_seconds = res_out.secs;

	// a word at the end of the pipeline waits unchanged while the queue is full
	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("back end lost or changed a stalled result");

	// an error result carries zero seconds
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && parse_error |-> epoch_seconds == '0)
		else $error("error result with nonzero seconds");

	// jobs come only from an accepted last byte
	a_job_source: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> push && !full && end_of_text)
		else $error("job pushed without an accepted last byte");

endmodule
